>>> rtl/rrf_pkg.sv
package rrf_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT       = 3'd0,
    CFG_TOP        = 3'd1,
    CFG_WIDTH      = 3'd2,
    CFG_HEIGHT     = 3'd3,
    CFG_RADIUS     = 3'd4,
    CFG_COLOR      = 3'd5,
    CFG_SRC_ALPHA  = 3'd6,
    CFG_DST_ALPHA  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

>>> rtl/rrf_in_if.sv
interface rrf_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [7:0]            dst_red;
  logic [7:0]            dst_green;
  logic [7:0]            dst_blue;
  logic [7:0]            dst_alpha;
  logic [2:0]            row_filter;

  modport source (
    output valid, pix_x, pix_y, dst_red, dst_green, dst_blue, dst_alpha, row_filter,
    input  ready
  );

  modport sink (
    input  valid, pix_x, pix_y, dst_red, dst_green, dst_blue, dst_alpha, row_filter,
    output ready
  );
endinterface

>>> rtl/rrf_out_if.sv
interface rrf_out_if;
  logic       valid;
  logic       ready;
  logic       covered;
  logic       written;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, covered, written, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, covered, written, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

>>> rtl/rrf_cover.sv
module rrf_cover #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] pix_x_i,
  input  logic [COORD_BITS-1:0] pix_y_i,
  input  logic [COORD_BITS-1:0] left_i,
  input  logic [COORD_BITS-1:0] top_i,
  input  logic [COORD_BITS-1:0] width_i,
  input  logic [COORD_BITS-1:0] height_i,
  input  logic [COORD_BITS-2:0] radius_i,
  output logic                  covered_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned RW = COORD_BITS - 1;
  localparam int unsigned SW = 2 * RW;

  logic [RW-1:0] r_min;
  logic [RW-1:0] half_w;
  logic [RW-1:0] half_h;
  logic [CW-1:0] r_ext;

  always_comb begin
    half_w = width_i[CW-1:1];
    half_h = height_i[CW-1:1];
    r_min  = radius_i;
    if (r_min > half_w) begin
      r_min = half_w;
    end
    if (r_min > half_h) begin
      r_min = half_h;
    end
    r_ext = {1'b0, r_min};
  end

  // offsets from the rectangle corner and the bounding box test
  logic [CW-1:0] dx_d, dy_d;
  logic [CW-1:0] dx_q, dy_q;
  logic          inr_d, inr1_q;

  always_comb begin
    dx_d  = pix_x_i - left_i;
    dy_d  = pix_y_i - top_i;
    inr_d = (pix_x_i >= left_i) && (pix_y_i >= top_i) && (dx_d < width_i) &&
            (dy_d < height_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      inr1_q <= inr_d;
    end
  end

  // pick the corner and form the offsets from its disc center
  logic [CW-1:0] w_r, h_r;
  logic          lo_x, hi_x, lo_y, hi_y;
  logic [CW-1:0] a_full, b_full;
  logic [RW-1:0] a_q, b_q;
  logic          corner_q, inr2_q, sharp2_q;

  always_comb begin
    w_r    = width_i - r_ext;
    h_r    = height_i - r_ext;
    lo_x   = dx_q < r_ext;
    hi_x   = dx_q >= w_r;
    lo_y   = dy_q < r_ext;
    hi_y   = dy_q >= h_r;
    a_full = lo_x ? (r_ext - dx_q) : (dx_q - w_r);
    b_full = lo_y ? (r_ext - dy_q) : (dy_q - h_r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= a_full[RW-1:0];
      b_q      <= b_full[RW-1:0];
      corner_q <= (lo_x || hi_x) && (lo_y || hi_y);
      inr2_q   <= inr1_q;
      sharp2_q <= (r_min == '0);
    end
  end

  logic [SW-1:0] aa_q, bb_q, rr_q;
  logic          corner3_q, inr3_q, sharp3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q      <= SW'(a_q) * SW'(a_q);
      bb_q      <= SW'(b_q) * SW'(b_q);
      rr_q      <= SW'(r_min) * SW'(r_min);
      corner3_q <= corner_q;
      inr3_q    <= inr2_q;
      sharp3_q  <= sharp2_q;
    end
  end

  logic [SW:0] dist_sq;

  always_comb begin
    dist_sq   = {1'b0, aa_q} + {1'b0, bb_q};
    covered_o = inr3_q && (sharp3_q || !corner3_q || (dist_sq <= {1'b0, rr_q}));
  end

endmodule

>>> rtl/rrf_blend.sv
module rrf_blend
  import rrf_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  rgba_t dst_i,
  input  rgba_t src_i,
  output rgba_t blend_o
);

  logic [7:0]  na;
  logic [15:0] pd_q [3];
  logic [15:0] ps_q [3];
  logic [7:0]  dst_c [3];
  logic [7:0]  src_c [3];
  logic [8:0]  sum [3];

  always_comb begin
    na       = ALPHA_MAX - src_i.alpha;
    dst_c[0] = dst_i.red;
    dst_c[1] = dst_i.green;
    dst_c[2] = dst_i.blue;
    src_c[0] = src_i.red;
    src_c[1] = src_i.green;
    src_c[2] = src_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= 16'(dst_c[i]) * 16'(na);
        ps_q[i] <= 16'(src_c[i]) * 16'(src_i.alpha);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {1'b0, div255(pd_q[i])} + {1'b0, div255(ps_q[i])};
    end
  end

  // alpha of the blend is never used
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blend_o <= {ALPHA_MAX, sum[2][7:0], sum[1][7:0], sum[0][7:0]};
    end
  end

endmodule

>>> rtl/rounded_rect_fill_blend_unit.sv
// Throughput: one pixel per cycle; the four-stage pipeline stalls as a whole
// while the output word waits, and the input is ready whenever the output
// register is empty or being taken.
// Reset: asynchronous, active low; clears all valid bits and loads the
// register defaults (dst_alpha = 1, all others 0).
module rounded_rect_fill_blend_unit
  import rrf_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rrf_in_if.sink                in_if,
  rrf_out_if.source             out_if
);

  logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;
  logic [COORD_BITS-2:0] radius_q;
  rgba_t                 color_q;
  logic                  src_alpha_q, dst_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      top_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      radius_q    <= '0;
      color_q     <= '0;
      src_alpha_q <= 1'b0;
      dst_alpha_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT:      left_q      <= cfg_data_i[COORD_BITS-1:0];
        CFG_TOP:       top_q       <= cfg_data_i[COORD_BITS-1:0];
        CFG_WIDTH:     width_q     <= cfg_data_i[COORD_BITS-1:0];
        CFG_HEIGHT:    height_q    <= cfg_data_i[COORD_BITS-1:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i[COORD_BITS-2:0];
        CFG_COLOR:     color_q     <= cfg_data_i[31:0];
        CFG_SRC_ALPHA: src_alpha_q <= cfg_data_i[0];
        CFG_DST_ALPHA: dst_alpha_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v1_q, v2_q, v3_q, out_v_q;

  // advance every stage together unless the output word is stuck
  assign en          = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_if.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= v3_q;
    end
  end

  rgba_t      dst_in;
  rgba_t      dst1_q, dst2_q, dst3_q;
  logic [2:0] filt1_q, filt2_q, filt3_q;
  rgba_t      blend;
  rgba_t      blend3_q;
  logic       covered;

  assign dst_in = {in_if.dst_alpha, in_if.dst_blue, in_if.dst_green, in_if.dst_red};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dst1_q   <= dst_in;
      dst2_q   <= dst1_q;
      dst3_q   <= dst2_q;
      filt1_q  <= in_if.row_filter;
      filt2_q  <= filt1_q;
      filt3_q  <= filt2_q;
      blend3_q <= blend;
    end
  end

  rrf_cover #(
    .COORD_BITS(COORD_BITS)
  ) u_rrf_cover (
    .clk_i     (clk_i),
    .en_i      (en),
    .pix_x_i   (in_if.pix_x),
    .pix_y_i   (in_if.pix_y),
    .left_i    (left_q),
    .top_i     (top_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .radius_i  (radius_q),
    .covered_o (covered)
  );

  rrf_blend u_rrf_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .dst_i   (dst_in),
    .src_i   (color_q),
    .blend_o (blend)
  );

  logic  wr;
  rgba_t res_d;
  rgba_t res_q;
  logic  cov_q, wr_q;

  always_comb begin
    wr    = covered && (filt3_q == 3'd0);
    res_d = dst3_q;
    if (wr) begin
      if (dst_alpha_q && src_alpha_q) begin
        res_d = {dst3_q.alpha, blend3_q.blue, blend3_q.green, blend3_q.red};
      end else if (dst_alpha_q) begin
        res_d = {ALPHA_MAX, color_q.blue, color_q.green, color_q.red};
      end else begin
        res_d = {dst3_q.alpha, color_q.blue, color_q.green, color_q.red};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cov_q <= covered;
      wr_q  <= wr;
      res_q <= res_d;
    end
  end

  assign out_if.valid     = out_v_q;
  assign out_if.covered   = cov_q;
  assign out_if.written   = wr_q;
  assign out_if.out_red   = res_q.red;
  assign out_if.out_green = res_q.green;
  assign out_if.out_blue  = res_q.blue;
  assign out_if.out_alpha = res_q.alpha;

endmodule

>>> rtl/rrf_checker.sv
module rrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       covered,
  input logic       written,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // a pixel is only changed where the shape covers it
  a_written_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && written |-> covered)
    else $error("written pixel not covered");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
      $stable({covered, written, out_red, out_green, out_blue, out_alpha}))
    else $error("stalled output word changed");

  // reset leaves the output empty on the following edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rounded_rect_fill_blend_unit rrf_checker u_rrf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .covered   (out_if.covered),
  .written   (out_if.written),
  .out_red   (out_if.out_red),
  .out_green (out_if.out_green),
  .out_blue  (out_if.out_blue),
  .out_alpha (out_if.out_alpha)
);
